[src/pwbt_pkg.sv]
// Package of the pulse-width byte transmitter: counter width, command and register codes,
// and the configuration type shared by the modules in src, plus the transmitter's result type.
// Depends on nothing.
`default_nettype none

package pwbt_pkg;

    localparam int CNT_W = 20;
    localparam int DUR_W = 20;
    localparam int CFG_IDX_W = 3;
    localparam int BYTE_W = 8;
    localparam int BITS_W = 4;
    localparam logic [BITS_W-1:0] BITS_PER_BYTE = 4'd8;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW  = 3'd5;

    localparam logic [DUR_W-1:0] RST_ZERO_HIGH = 20'd55555;
    localparam logic [DUR_W-1:0] RST_ZERO_LOW  = 20'd111110;
    localparam logic [DUR_W-1:0] RST_ONE_HIGH  = 20'd111110;
    localparam logic [DUR_W-1:0] RST_ONE_LOW   = 20'd55555;
    localparam logic [DUR_W-1:0] RST_SYNC_HIGH = 20'd249999;
    localparam logic [DUR_W-1:0] RST_SYNC_LOW  = 20'd83333;

    typedef struct packed {
        logic [DUR_W-1:0] zero_high;
        logic [DUR_W-1:0] zero_low;
        logic [DUR_W-1:0] one_high;
        logic [DUR_W-1:0] one_low;
        logic [DUR_W-1:0] sync_high;
        logic [DUR_W-1:0] sync_low;
    } t_cfg;

    // Packed from the top, so line_level sits in bit 0.
    typedef struct packed {
        logic frame_done;
        logic load_rejected;
        logic byte_accepted;
        logic busy_res;
        logic line_level;
    } t_result;

    localparam int RES_W = $bits(t_result);
    localparam int OUT_DATA_W = 8;

endpackage

`default_nettype wire

[src/pulse_width_byte_transmitter.sv]
// An accepted request has its result in the output register in the next cycle.
// Throughput: one request per cycle while no untaken result stalls it; the phase counter
// and bit shifter update in one pass. A result waiting in the output register does not
// stop the next request while the downstream side takes it in the same cycle.
// Reset (synchronous, active low): line idle and low, durations at their defaults,
// output register empty.
`default_nettype none

module pulse_width_byte_transmitter (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [pwbt_pkg::BYTE_W-1:0]     i_s_tdata,  // [7:0] data_byte
    input  wire logic                            i_s_tuser,  // [0] command
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // [0] line_level, [1] busy_res, [2] byte_accepted, [3] load_rejected,
    // [4] frame_done, [7:5] zero
    output logic [pwbt_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [pwbt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pwbt_pkg::DUR_W-1:0]      i_cfg_data
);
    import pwbt_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_SYNC_PRE  = 3'd1,
        PH_SYNC_HIGH = 3'd2,
        PH_SYNC_POST = 3'd3,
        PH_BIT_HIGH  = 3'd4,
        PH_BIT_LOW   = 3'd5
    } t_phase;

    t_cfg              cfg;
    t_phase            r_phase, n_phase;
    logic [CNT_W-1:0]  r_ticks, n_ticks;
    logic [BYTE_W-1:0] r_shift, n_shift;
    logic [BITS_W-1:0] r_bits, n_bits;
    logic              r_out_valid;
    t_result           r_res, n_res;
    logic              s_fire;
    logic              busy;
    logic              level;
    logic [BYTE_W-1:0] shifted;
    logic [BITS_W-1:0] bits_dec;

    assign o_cfg_ready = 1'b1;

    pwbt_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_fire     = i_s_tvalid && o_s_tready;

    always_comb begin
        case (r_phase)
            PH_SYNC_PRE, PH_SYNC_POST, PH_BIT_LOW: begin
                busy  = 1'b1;
                level = 1'b0;
            end
            PH_SYNC_HIGH, PH_BIT_HIGH: begin
                busy  = 1'b1;
                level = 1'b1;
            end
            default: begin
                busy  = 1'b0;
                level = 1'b0;
            end
        endcase
    end

    assign shifted  = {r_shift[BYTE_W-2:0], 1'b0};
    assign bits_dec = r_bits - BITS_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_ticks = r_ticks;
        n_shift = r_shift;
        n_bits  = r_bits;
        n_res   = '0;
        if (i_s_tuser == CMD_LOAD) begin
            if (busy) begin
                n_res.load_rejected = 1'b1;
                n_res.busy_res      = 1'b1;
                n_res.line_level    = level;
            end else begin
                n_res.byte_accepted = 1'b1;
                n_res.busy_res      = 1'b1;
                n_shift             = i_s_tdata;
                n_bits              = BITS_PER_BYTE;
                n_phase             = PH_SYNC_PRE;
                n_ticks             = CNT_W'(cfg.sync_low);
            end
        end else if (busy) begin
            n_res.busy_res   = 1'b1;
            n_res.line_level = level;
            if (r_ticks <= CNT_W'(1)) begin
                case (r_phase)
                    PH_SYNC_PRE: begin
                        n_phase = PH_SYNC_HIGH;
                        n_ticks = CNT_W'(cfg.sync_high);
                    end
                    PH_SYNC_HIGH: begin
                        n_phase = PH_SYNC_POST;
                        n_ticks = CNT_W'(cfg.sync_low);
                    end
                    PH_SYNC_POST: begin
                        n_phase = PH_BIT_HIGH;
                        n_ticks = r_shift[BYTE_W-1] ? CNT_W'(cfg.one_high)
                                                    : CNT_W'(cfg.zero_high);
                    end
                    PH_BIT_HIGH: begin
                        n_phase = PH_BIT_LOW;
                        n_ticks = r_shift[BYTE_W-1] ? CNT_W'(cfg.one_low)
                                                    : CNT_W'(cfg.zero_low);
                    end
                    PH_BIT_LOW: begin
                        n_shift = shifted;
                        n_bits  = bits_dec;
                        if (bits_dec == '0) begin
                            n_phase          = PH_IDLE;
                            n_ticks          = '0;
                            n_res.frame_done = 1'b1;
                        end else begin
                            n_phase = PH_BIT_HIGH;
                            n_ticks = shifted[BYTE_W-1] ? CNT_W'(cfg.one_high)
                                                        : CNT_W'(cfg.zero_high);
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_ticks = '0;
                    end
                endcase
            end else begin
                n_ticks = r_ticks - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_ticks     <= '0;
            r_shift     <= '0;
            r_bits      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_fire) begin
                r_phase     <= n_phase;
                r_ticks     <= n_ticks;
                r_shift     <= n_shift;
                r_bits      <= n_bits;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_DATA_W - RES_W)'(0), r_res};

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.byte_accepted && r_res.load_rejected))
        else $error("byte accepted and rejected in one result");

    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.frame_done) |-> (r_res.busy_res && r_phase == PH_IDLE))
        else $error("frame done reported without a finished frame");

    a_bit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= BITS_PER_BYTE)
        else $error("bit counter out of range");

    a_load_starts_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && i_s_tuser == CMD_LOAD && r_phase == PH_IDLE)
            |=> (r_phase == PH_SYNC_PRE && r_bits == BITS_PER_BYTE))
        else $error("accepted load did not start a sync");
`endif

endmodule

`default_nettype wire

[src/pwbt_cfg_regs.sv]
// Configuration register file of the pulse-width byte transmitter: six tick durations.
// Depends on pwbt_pkg.
`default_nettype none

module pwbt_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr_en,
    input  wire logic [pwbt_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  wire logic [pwbt_pkg::DUR_W-1:0]     i_wr_data,
    output pwbt_pkg::t_cfg                      o_cfg
);
    import pwbt_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_high <= RST_ZERO_HIGH;
            r_cfg.zero_low  <= RST_ZERO_LOW;
            r_cfg.one_high  <= RST_ONE_HIGH;
            r_cfg.one_low   <= RST_ONE_LOW;
            r_cfg.sync_high <= RST_SYNC_HIGH;
            r_cfg.sync_low  <= RST_SYNC_LOW;
        end else if (i_wr_en) begin
            case (i_wr_index)
                REG_ZERO_HIGH: r_cfg.zero_high <= i_wr_data;
                REG_ZERO_LOW:  r_cfg.zero_low  <= i_wr_data;
                REG_ONE_HIGH:  r_cfg.one_high  <= i_wr_data;
                REG_ONE_LOW:   r_cfg.one_low   <= i_wr_data;
                REG_SYNC_HIGH: r_cfg.sync_high <= i_wr_data;
                REG_SYNC_LOW:  r_cfg.sync_low  <= i_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire
